// ===== sv/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// Open handle clock cache package
// Sizes, status and command codes and the sequencer state type shared by
// the cache top level.
// ----------------------------------------------------------------------------
package occ_pkg;

    // Table geometry.
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 16;

    // Derived widths: a slot index, a count that can hold ENTRIES, and a
    // sweep step count that can hold twice ENTRIES.
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int STEP_W = $clog2(2 * ENTRIES + 1);

    // Port field widths.
    localparam int KEY_IN_W  = 16;
    localparam int MAXOPEN_W = 5;
    localparam int SLOT_W    = 4;
    localparam int CLOSED_W  = 5;

    // Width used to compare the open count with the limit.
    localparam int CMP_W = (CNT_W > MAXOPEN_W) ? CNT_W : MAXOPEN_W;

    // Limit on open records after reset.
    localparam logic [MAXOPEN_W-1:0] MAX_OPEN_RESET = MAXOPEN_W'(16);

    // Command codes.
    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ABSENT   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP,
        S_ACT
    } state_t;

endpackage

// ===== sv/occ_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single port write, single port read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module occ_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== sv/open_handle_clock_cache.sv =====
// From the accepted beat to the result beat, the key search reads one filled
// record after another and stops early on a hit. An insert then runs the clock
// sweep while the open count is at or above the limit (at most 2 * ENTRIES steps),
// leaves it, and then updates the record and registers the result. One item at a
// time: the next beat is taken only once the sequencer is back in idle, after the
// result is registered. Synchronous active low reset empties the table.
// ----------------------------------------------------------------------------
// Open handle clock cache
// Table of file records with a second chance clock sweep that closes unused
// open records, driven by a small sequencer around one key RAM.
// ----------------------------------------------------------------------------
module open_handle_clock_cache (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [occ_pkg::MAXOPEN_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [occ_pkg::KEY_IN_W-1:0]   s_key_id,
    input  logic                           s_open_ok,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [occ_pkg::SLOT_W-1:0]     m_slot,
    output logic                           m_is_open,
    output logic                           m_is_broken,
    output logic [occ_pkg::CLOSED_W-1:0]   m_closed_count
);

    import occ_pkg::*;

    // Control state.
    state_t                 state_reg, state_next;
    logic [ENTRIES-1:0]     used_reg, used_next;
    logic [ENTRIES-1:0]     open_reg, open_next;
    logic [ENTRIES-1:0]     broken_reg, broken_next;
    logic [IDX_W-1:0]       hand_reg, hand_next;
    logic [CNT_W-1:0]       open_cnt_reg, open_cnt_next;
    logic [CNT_W-1:0]       rec_cnt_reg, rec_cnt_next;
    logic [MAXOPEN_W-1:0]   max_open_reg;
    logic                   m_valid_reg, m_valid_next;

    // Per item working registers and result payload.
    logic                   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   ok_reg, ok_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic [CNT_W-1:0]       closed_reg, closed_next;
    status_t                status_reg, status_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   is_open_reg, is_open_next;
    logic                   is_broken_reg, is_broken_next;
    logic [CLOSED_W-1:0]    closed_out_reg, closed_out_next;

    // Key RAM.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [KEY_BITS-1:0]    ram_rdata;

    // Decoded conditions.
    logic                   in_beat;
    logic                   act_fire;
    logic                   lookup_hit;
    logic                   lookup_more;
    logic                   table_full;
    logic                   sweep_go;
    logic [IDX_W-1:0]       sweep_slot;

    occ_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (key_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Handshake and condition decode.
    assign s_ready     = (state_reg == S_IDLE);
    assign in_beat     = s_valid && s_ready;
    assign act_fire    = (state_reg == S_ACT) && (!m_valid_reg || m_ready);
    assign lookup_hit  = cmp_pend_reg && (ram_rdata == key_reg);
    assign lookup_more = (scan_reg < rec_cnt_reg);
    assign table_full  = (rec_cnt_reg >= CNT_W'(ENTRIES));
    assign sweep_go    = (CMP_W'(open_cnt_reg) >= CMP_W'(max_open_reg))
                         && (rec_cnt_reg != '0)
                         && (steps_reg < STEP_W'(2 * ENTRIES));
    assign sweep_slot  = (CNT_W'(hand_reg) >= rec_cnt_reg) ? '0 : hand_reg;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (lookup_hit) begin
                    state_next = S_ACT;
                end else if (!lookup_more) begin
                    if ((cmd_reg == CMD_FIND) && !table_full) begin
                        state_next = S_SWEEP;
                    end else begin
                        state_next = S_ACT;
                    end
                end
            end
            S_SWEEP: begin
                if (!sweep_go) begin
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                if (act_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        used_next       = used_reg;
        open_next       = open_reg;
        broken_next     = broken_reg;
        hand_next       = hand_reg;
        open_cnt_next   = open_cnt_reg;
        rec_cnt_next    = rec_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        ok_next         = ok_reg;
        scan_next       = scan_reg;
        cmp_pend_next   = cmp_pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        steps_next      = steps_reg;
        closed_next     = closed_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        is_open_next    = is_open_reg;
        is_broken_next  = is_broken_reg;
        closed_out_next = closed_out_reg;
        ram_we          = 1'b0;
        ram_raddr       = scan_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                // Capture the input beat and reset the per item counters.
                if (in_beat) begin
                    cmd_next      = s_command;
                    key_next      = KEY_BITS'(s_key_id);
                    ok_next       = s_open_ok;
                    scan_next     = '0;
                    cmp_pend_next = 1'b0;
                    steps_next    = '0;
                    closed_next   = '0;
                end
            end
            S_LOOKUP: begin
                // One key read issued and one compared each cycle.
                if (lookup_hit) begin
                    hit_next      = 1'b1;
                    idx_next      = cmp_idx_reg;
                    cmp_pend_next = 1'b0;
                end else if (lookup_more) begin
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end else begin
                    hit_next      = 1'b0;
                    idx_next      = rec_cnt_reg[IDX_W-1:0];
                    cmp_pend_next = 1'b0;
                end
            end
            S_SWEEP: begin
                // One clock step: a used record gets a second chance, an
                // unused open record is closed.
                if (sweep_go) begin
                    if (used_reg[sweep_slot]) begin
                        used_next[sweep_slot] = 1'b0;
                    end else if (open_reg[sweep_slot]) begin
                        open_next[sweep_slot] = 1'b0;
                        if (open_cnt_reg != '0) begin
                            open_cnt_next = open_cnt_reg - CNT_W'(1);
                        end
                        closed_next = closed_reg + CNT_W'(1);
                    end
                    hand_next  = (sweep_slot == IDX_W'(ENTRIES - 1)) ? '0
                                 : sweep_slot + IDX_W'(1);
                    steps_next = steps_reg + STEP_W'(1);
                end
            end
            S_ACT: begin
                // Apply the command to the record and register the result.
                if (act_fire) begin
                    m_valid_next    = 1'b1;
                    status_next     = ST_HIT;
                    slot_next       = SLOT_W'(idx_reg);
                    closed_out_next = '0;
                    if (cmd_reg == CMD_READ) begin
                        if (!hit_reg) begin
                            status_next = ST_ABSENT;
                            slot_next   = '0;
                        end else if (!open_reg[idx_reg] && !broken_reg[idx_reg]) begin
                            if (ok_reg) begin
                                open_next[idx_reg] = 1'b1;
                                used_next[idx_reg] = 1'b1;
                                open_cnt_next      = open_cnt_reg + CNT_W'(1);
                            end else begin
                                broken_next[idx_reg] = 1'b1;
                            end
                        end
                    end else if (hit_reg) begin
                        used_next[idx_reg] = 1'b1;
                    end else if (table_full) begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                    end else begin
                        // Insert at the next free slot and try to open it.
                        ram_we               = 1'b1;
                        used_next[idx_reg]   = 1'b1;
                        open_next[idx_reg]   = ok_reg;
                        broken_next[idx_reg] = !ok_reg;
                        if (ok_reg) begin
                            open_cnt_next = open_cnt_reg + CNT_W'(1);
                        end
                        rec_cnt_next    = rec_cnt_reg + CNT_W'(1);
                        status_next     = ST_INSERTED;
                        closed_out_next = CLOSED_W'(closed_reg);
                    end
                    if ((status_next == ST_FULL) || (status_next == ST_ABSENT)) begin
                        is_open_next   = 1'b0;
                        is_broken_next = 1'b0;
                    end else begin
                        is_open_next   = open_next[idx_reg];
                        is_broken_next = broken_next[idx_reg];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            open_reg     <= '0;
            broken_reg   <= '0;
            hand_reg     <= '0;
            open_cnt_reg <= '0;
            rec_cnt_reg  <= '0;
            max_open_reg <= MAX_OPEN_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            open_reg     <= open_next;
            broken_reg   <= broken_next;
            hand_reg     <= hand_next;
            open_cnt_reg <= open_cnt_next;
            rec_cnt_reg  <= rec_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                max_open_reg <= cfg_wr_data;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        ok_reg         <= ok_next;
        scan_reg       <= scan_next;
        cmp_pend_reg   <= cmp_pend_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        idx_reg        <= idx_next;
        steps_reg      <= steps_next;
        closed_reg     <= closed_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        is_open_reg    <= is_open_next;
        is_broken_reg  <= is_broken_next;
        closed_out_reg <= closed_out_next;
    end

    // Result beat.
    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_slot         = slot_reg;
    assign m_is_open      = is_open_reg;
    assign m_is_broken    = is_broken_reg;
    assign m_closed_count = closed_out_reg;

endmodule
